>>> rtl/vrra_pkg.sv
// Package for the variable record ring allocator: sizes, opcodes, status codes.
// No dependencies.
`timescale 1ns / 1ps
package vrra_pkg;
    localparam int unsigned ArenaBytes   = 16777216;
    localparam int unsigned LineCap      = 4096;
    localparam int unsigned SegmentBytes = 8;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_SETROW = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_ENFCAP = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] line_index;
        logic [9:0]  segment_count;
        logic [15:0] text_length;
        logic [15:0] row_count;
        logic [7:0]  line_flags;
        logic [31:0] timestamp;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] evicted_rows;
        logic [23:0] record_offset;
        logic [15:0] out_length;
        logic [15:0] out_rows;
        logic [9:0]  out_segments;
        logic [7:0]  out_flags;
        logic [31:0] out_time;
        logic [12:0] lines_held;
        logic [31:0] total_evicted;
    } t_rsp;

    // Descriptor word held in memory: offset, length, rows, segments, flags, time
    localparam int DescW = 24 + 16 + 16 + 10 + 8 + 32;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction
endpackage

>>> rtl/vrra_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface vrra_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vrra_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vrra_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> rtl/variable_record_ring_allocator_unit.sv
// Top level of the variable record ring allocator: sequencer over a descriptor RAM.
// Depends on vrra_pkg, vrra_if, vrra_ram.
//
//  channel  | dir | payload
//  i_req    | in  | vrra_pkg::t_req (opcode, index, line fields)
//  o_rsp    | out | vrra_pkg::t_rsp (status, offsets, descriptor, counts)
//  cfg      | in  | i_cfg_we / i_cfg_wdata : max_lines
//
// States from accepted transfer to result valid: clear passes LOOK, then OUT; read, set
// rows, enforce cap and undefined codes pass LOOK, DEC, OUT (RAM read, decide, result);
// append adds PLACE. Each oldest line evicted adds EVICT, reissues the head read, decides again.
// Reset (synchronous) empties the ring; descriptor RAM contents are not cleared.
// A result waits in the output register; a new request is taken the cycle after it leaves.
`timescale 1ns / 1ps
module variable_record_ring_allocator_unit #(
    parameter int unsigned ARENA_BYTES   = vrra_pkg::ArenaBytes,
    parameter int unsigned LINE_CAP      = vrra_pkg::LineCap,
    parameter int unsigned SEGMENT_BYTES = vrra_pkg::SegmentBytes
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vrra_if.sink          i_req,
    vrra_if.source        o_rsp,
    input  logic          i_cfg_we,
    input  logic [12:0]   i_cfg_wdata
);
    import vrra_pkg::*;

    localparam int AW = $clog2(LINE_CAP);
    localparam int PW = $clog2(ARENA_BYTES) + 1;
    localparam logic [AW:0] CapMax = (AW+1)'(LINE_CAP);
    localparam logic [PW-1:0] ArenaP = PW'(ARENA_BYTES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOOK  = 6'b000010,
        S_DEC   = 6'b000100,
        S_EVICT = 6'b001000,
        S_PLACE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    t_req          r_req;
    t_rsp          r_rsp, n_rsp;
    logic [12:0]   r_max;
    logic [AW-1:0] r_head, n_head;
    logic [AW:0]   r_total, n_total;
    logic [PW-1:0] r_wp, n_wp;
    logic [31:0]   r_evc, n_evc;
    logic [31:0]   r_ev, n_ev;
    logic [PW:0]   r_rec;
    logic [PW-1:0] r_start, n_start;
    logic          r_rsp_v, n_rsp_v;

    // descriptor RAM
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [DescW-1:0] ram_wdata, ram_rdata;
    logic [23:0] d_off;
    logic [15:0] d_len, d_rows;
    logic [9:0]  d_seg;
    logic [7:0]  d_flg;
    logic [31:0] d_time;

    vrra_ram #(.Width(DescW), .Depth(LINE_CAP)) u_desc (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );
    assign {d_off, d_len, d_rows, d_seg, d_flg, d_time} = ram_rdata;

    // clamped cap
    logic [AW:0] cap;
    always_comb begin
        if (r_max == 13'd0) begin
            cap = (AW+1)'(1);
        end else if ({19'd0, r_max} > 32'(LINE_CAP)) begin
            cap = CapMax;
        end else begin
            cap = (AW+1)'(r_max);
        end
    end

    // slot of a logical index, wraps at the ring size
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [AW:0] l);
        logic [AW+1:0] s;
        s = {1'b0, h} + {1'b0, l};
        if (s >= (AW+2)'(LINE_CAP)) begin
            s = s - (AW+2)'(LINE_CAP);
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] head_inc;
    assign head_inc = (32'(r_head) + 1 >= LINE_CAP) ? '0 : r_head + AW'(1);

    logic [PW:0] wp_end;
    logic [PW:0] oldest;
    assign wp_end = {1'b0, r_wp} + r_rec;
    assign oldest = (PW+1)'(d_off);

    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_v;
    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.data  = r_rsp;

    logic [AW:0] idx_ext;
    assign idx_ext = (AW+1)'(r_req.line_index);

    always_comb begin
        n_state = r_state;
        n_rsp = r_rsp;
        n_rsp_v = r_rsp_v && !o_rsp.ready;
        n_head = r_head;
        n_total = r_total;
        n_wp = r_wp;
        n_evc = r_evc;
        n_ev = r_ev;
        n_start = r_start;
        ram_we = 1'b0;
        ram_waddr = slot_of(r_head, r_total);
        ram_wdata = {24'(r_start), r_req.text_length, r_req.row_count,
                     r_req.segment_count, r_req.line_flags, r_req.timestamp};
        ram_raddr = r_head;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_state = S_LOOK;
                    n_ev = '0;
                end
            end
            S_LOOK: begin
                // issue head or indexed read
                ram_raddr = (r_req.opcode == OP_READ || r_req.opcode == OP_SETROW)
                          ? slot_of(r_head, idx_ext) : r_head;
                n_state = S_DEC;
                if (r_req.opcode == OP_CLEAR) begin
                    n_head = '0; n_total = '0; n_wp = '0; n_evc = '0;
                    n_state = S_OUT;
                end
            end
            S_DEC: begin
                n_state = S_OUT;
                case (r_req.opcode)
                    OP_APPEND: begin
                        if (r_total == '0) begin
                            n_wp = '0; n_start = '0; n_state = S_PLACE;
                        end else if (r_total >= cap) begin
                            n_state = S_EVICT;
                        end else if (oldest <= {1'b0, r_wp}) begin
                            if (wp_end <= {1'b0, ArenaP}) begin
                                n_start = r_wp; n_state = S_PLACE;
                            end else if (r_rec < oldest) begin
                                n_start = '0; n_state = S_PLACE;
                            end else begin
                                n_state = S_EVICT;
                            end
                        end else if (wp_end < oldest) begin
                            n_start = r_wp; n_state = S_PLACE;
                        end else begin
                            n_state = S_EVICT;
                        end
                    end
                    OP_READ: begin
                        // keep the indexed entry on the read port for the result
                        ram_raddr = slot_of(r_head, idx_ext);
                    end
                    OP_ENFCAP: begin
                        if (r_total > cap) n_state = S_EVICT;
                    end
                    OP_SETROW: begin
                        if (idx_ext < r_total) begin
                            ram_we = 1'b1;
                            ram_waddr = slot_of(r_head, idx_ext);
                            ram_wdata = {d_off, d_len, r_req.row_count, d_seg, d_flg, d_time};
                        end
                    end
                    default: ;
                endcase
            end
            S_EVICT: begin
                // head descriptor is valid in ram_rdata
                n_ev = sat_add(r_ev, {16'd0, d_rows});
                n_head = head_inc;
                n_total = r_total - (AW+1)'(1);
                n_evc = r_evc + 32'd1;
                if (r_total == (AW+1)'(1)) n_wp = '0;
                ram_raddr = head_inc;
                n_state = S_LOOK;
            end
            S_PLACE: begin
                if ({1'b0, r_start} + r_rec > {1'b0, ArenaP}) begin
                    n_wp = '0;
                end else begin
                    ram_we = 1'b1;
                    n_total = r_total + (AW+1)'(1);
                    n_wp = PW'({1'b0, r_start} + r_rec);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                n_rsp = '0;
                n_rsp.lines_held = 13'(r_total);
                n_rsp.total_evicted = r_evc;
                case (r_req.opcode)
                    OP_APPEND: begin
                        if ({1'b0, r_start} + r_rec > {1'b0, ArenaP}) begin
                            n_rsp.status = ST_DROP;
                            n_rsp.evicted_rows = sat_add(r_ev, {16'd0, r_req.row_count});
                        end else begin
                            n_rsp.evicted_rows = r_ev;
                            n_rsp.record_offset = 24'(r_start);
                        end
                    end
                    OP_READ, OP_SETROW: begin
                        if (idx_ext >= r_total) begin
                            n_rsp.status = ST_RANGE;
                        end else if (r_req.opcode == OP_READ) begin
                            n_rsp.record_offset = d_off;
                            n_rsp.out_length = d_len;
                            n_rsp.out_rows = d_rows;
                            n_rsp.out_segments = d_seg;
                            n_rsp.out_flags = d_flg;
                            n_rsp.out_time = d_time;
                        end
                    end
                    OP_ENFCAP: n_rsp.evicted_rows = r_ev;
                    default: ;
                endcase
                n_rsp_v = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // record size computed at accept
    logic [PW+1:0] rec_raw;
    assign rec_raw = (PW+2)'(i_req.data.segment_count) * (PW+2)'(SEGMENT_BYTES)
                   + (PW+2)'(i_req.data.text_length) + (PW+2)'(3);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp_v <= 1'b0;
            r_head  <= '0;
            r_total <= '0;
            r_wp    <= '0;
            r_evc   <= '0;
            r_max   <= 13'd4096;
        end else begin
            r_state <= n_state;
            r_rsp_v <= n_rsp_v;
            r_head  <= n_head;
            r_total <= n_total;
            r_wp    <= n_wp;
            r_evc   <= n_evc;
            if (i_cfg_we) r_max <= i_cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
            r_rec <= (PW+1)'({rec_raw[PW+1:2], 2'b00});
        end
        r_rsp   <= n_rsp;
        r_ev    <= n_ev;
        r_start <= n_start;
    end

`ifndef SYNTHESIS
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CapMax) else $error("line total beyond ring size");
    a_empty_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_total == '0) |-> r_wp == '0)
        else $error("write pointer not reset on empty ring");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
`endif
endmodule

>>> dv/variable_record_ring_allocator_unit_tb.sv
// Self-checking testbench for variable_record_ring_allocator_unit: random and directed requests
// on valid/ready channels, with an in-bench ring/arena predictor held in a scoreboard class.
// Depends on vrra_pkg, vrra_if and the RTL top level.
`timescale 1ns / 1ps
module variable_record_ring_allocator_unit_tb;
    import vrra_pkg::*;

    localparam int unsigned ARENA = vrra_pkg::ArenaBytes;
    localparam int unsigned RING  = vrra_pkg::LineCap;
    localparam int unsigned SEGB  = vrra_pkg::SegmentBytes;

    // Ring predictor plus queue of predicted responses
    class ring_scoreboard;
        logic [23:0] d_off [RING];
        logic [15:0] d_len [RING];
        logic [15:0] d_rows[RING];
        logic [9:0]  d_segs[RING];
        logic [7:0]  d_flags[RING];
        logic [31:0] d_time[RING];
        int unsigned head;
        int unsigned count;
        int unsigned wptr;
        logic [31:0] evicted;
        logic [12:0] cap_reg;
        t_rsp        pending[$];
        int          errors;

        function new();
            head = 0; count = 0; wptr = 0; evicted = 0; cap_reg = 13'd4096; errors = 0;
        endfunction

        function int unsigned cap_clamped();
            if (cap_reg < 1) return 1;
            if (cap_reg > RING) return RING;
            return cap_reg;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function int unsigned slot(int unsigned logical);
            int unsigned s;
            s = head + logical;
            if (s >= RING) s -= RING;
            return s;
        endfunction

        // drop the oldest line, return its rows
        function logic [31:0] drop_oldest();
            logic [31:0] r;
            r = d_rows[head];
            head = (head + 1 >= RING) ? 0 : head + 1;
            count--;
            evicted++;
            if (count == 0) wptr = 0;
            return r;
        endfunction

        function void note_request(t_req q);
            t_rsp        e;
            logic [31:0] ev;
            int unsigned rec, start, oldest, cap, s;
            e = '0;
            ev = 0;
            case (q.opcode)
                OP_APPEND: begin
                    rec = (q.segment_count * SEGB + q.text_length + 3) & ~32'd3;
                    start = 0;
                    cap = cap_clamped();
                    forever begin
                        if (count == 0) begin
                            wptr = 0;
                            break;
                        end
                        if (count < cap) begin
                            oldest = d_off[slot(0)];
                            if (oldest <= wptr) begin
                                if (wptr + rec <= ARENA) begin
                                    start = wptr;
                                    break;
                                end
                                if (rec < oldest) begin
                                    start = 0;
                                    break;
                                end
                            end else if (wptr + rec < oldest) begin
                                start = wptr;
                                break;
                            end
                        end
                        ev = add_sat(ev, drop_oldest());
                    end
                    if (start + rec > ARENA) begin
                        e.status = ST_DROP;
                        e.evicted_rows = add_sat(ev, q.row_count);
                    end else begin
                        s = slot(count);
                        d_off[s] = 24'(start);
                        d_len[s] = q.text_length;
                        d_rows[s] = q.row_count;
                        d_segs[s] = q.segment_count;
                        d_flags[s] = q.line_flags;
                        d_time[s] = q.timestamp;
                        count++;
                        wptr = start + rec;
                        e.evicted_rows = ev;
                        e.record_offset = 24'(start);
                    end
                end
                OP_READ, OP_SETROW: begin
                    if (q.line_index >= count) begin
                        e.status = ST_RANGE;
                    end else begin
                        s = slot(q.line_index);
                        if (q.opcode == OP_READ) begin
                            e.record_offset = d_off[s];
                            e.out_length = d_len[s];
                            e.out_rows = d_rows[s];
                            e.out_segments = d_segs[s];
                            e.out_flags = d_flags[s];
                            e.out_time = d_time[s];
                        end else begin
                            d_rows[s] = q.row_count;
                        end
                    end
                end
                OP_CLEAR: begin
                    head = 0; count = 0; wptr = 0; evicted = 0;
                end
                OP_ENFCAP: begin
                    cap = cap_clamped();
                    while (count > cap) ev = add_sat(ev, drop_oldest());
                    e.evicted_rows = ev;
                end
                default: ;
            endcase
            e.lines_held = 13'(count);
            e.total_evicted = evicted;
            pending.push_back(e);
        endfunction

        function void cmp(string name, logic [31:0] x, logic [31:0] a);
            if (x !== a) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, x, a);
                errors++;
            end
        endfunction

        function void check_response(t_rsp a);
            t_rsp x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %0h", $time, a);
                errors++;
                return;
            end
            x = pending.pop_front();
            cmp("status", x.status, a.status);
            cmp("evicted_rows", x.evicted_rows, a.evicted_rows);
            cmp("record_offset", x.record_offset, a.record_offset);
            cmp("out_length", x.out_length, a.out_length);
            cmp("out_rows", x.out_rows, a.out_rows);
            cmp("out_segments", x.out_segments, a.out_segments);
            cmp("out_flags", x.out_flags, a.out_flags);
            cmp("out_time", x.out_time, a.out_time);
            cmp("lines_held", x.lines_held, a.lines_held);
            cmp("total_evicted", x.total_evicted, a.total_evicted);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [12:0] i_cfg_wdata;

    vrra_if #(.T(t_req)) req_if (i_clk);
    vrra_if #(.T(t_rsp)) rsp_if (i_clk);

    variable_record_ring_allocator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ring_scoreboard sb;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // one request transfer, after a random gap
    task automatic send_req(t_req r);
        int gap;
        gap = $urandom_range(0, 17);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cap(logic [12:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.cap_reg = v;
    endtask

    function automatic t_req rand_req(bit small_rec);
        t_req r;
        int   pick;
        r.opcode        = OP_APPEND;
        r.line_index    = 12'($urandom());
        r.segment_count = small_rec ? 10'($urandom_range(0, 3)) : 10'($urandom());
        r.text_length   = small_rec ? 16'($urandom_range(0, 63)) : 16'($urandom());
        r.row_count     = 16'($urandom());
        r.line_flags    = 8'($urandom());
        r.timestamp     = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 50) r.opcode = OP_APPEND;
        else if (pick < 75) r.opcode = OP_READ;
        else if (pick < 85) r.opcode = OP_SETROW;
        else if (pick < 92) r.opcode = OP_ENFCAP;
        else if (pick < 95) r.opcode = OP_CLEAR;
        else r.opcode = 3'($urandom_range(5, 7));
        // mostly in-range indices
        if ((r.opcode == OP_READ || r.opcode == OP_SETROW) && sb.count > 0
                && $urandom_range(0, 9) < 8)
            r.line_index = 12'($urandom_range(0, sb.count - 1));
        return r;
    endfunction

    // response side: random stall per transfer
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    end

    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_req        r;
        logic [12:0] caps[7];
        bit          smalls[7];
        sb = new();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        caps   = '{13'd4096, 13'd1, 13'h1FFF, 13'd2, 13'd0, 13'd37, 13'd4096};
        smalls = '{0, 1, 0, 1, 1, 0, 1};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, each opcode, out of range, clear, undefined codes
        r = '0;
        r.line_index = 12'hFFF;
        r.opcode = OP_READ;   send_req(r);
        r.opcode = OP_APPEND; send_req(r);
        r = '1;
        r.opcode = OP_APPEND; send_req(r);
        r.line_index = 0;
        r.opcode = OP_READ;   send_req(r);
        r.line_index = 1;     send_req(r);
        r.line_index = 2;     send_req(r);
        r.opcode = OP_SETROW; r.row_count = 16'h0; send_req(r);
        r.opcode = OP_READ;   send_req(r);
        r.opcode = OP_SETROW; r.line_index = 12'hFFF; send_req(r);
        r.opcode = OP_ENFCAP; send_req(r);
        for (int k = 5; k < 8; k++) begin
            r.opcode = 3'(k);
            send_req(r);
        end
        r.opcode = OP_CLEAR;  send_req(r);
        r.opcode = OP_READ;   r.line_index = 0; send_req(r);
        r.opcode = OP_APPEND; send_req(r);

        // random phases over several cap settings
        for (int p = 0; p < 7; p++) begin
            write_cap(caps[p]);
            r = '0;
            r.opcode = OP_ENFCAP;
            send_req(r);
            for (int n = 0; n < 300; n++) send_req(rand_req(smalls[p]));
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> variable_record_ring_allocator_unit.f
rtl/vrra_pkg.sv
rtl/vrra_if.sv
rtl/vrra_ram.sv
rtl/variable_record_ring_allocator_unit.sv
dv/variable_record_ring_allocator_unit_tb.sv
